FILE: hw/rtl/clq_pkg.sv
// Shared types and constants for the circular linked queue manager.
package clq_pkg;

  localparam int ELEM_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int STATUS_W      = 2;
  localparam int DEF_MAX_ELEMS = 16;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_LINKED    = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ELEM_W-1:0] elem;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               head_valid;
    logic [ELEM_W-1:0]  head;
  } res_t;

endpackage

FILE: hw/rtl/clq_in_reg.sv
// Input register stage: holds one accepted transaction until the list update takes it.
module clq_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clq_pkg::item_t in_item,
  input  logic          advance,
  output logic          vld_r,
  output clq_pkg::item_t item_r
);
  import clq_pkg::*;

  logic accept;
  logic vld_nxt;

  // Stall only while a held transaction cannot move on.
  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: hw/rtl/clq_list.sv
// Queue state (link tables, linked flags, head, tail, count) and the single-pass update.
module clq_list #(
  parameter int MAX_ELEMS = clq_pkg::DEF_MAX_ELEMS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  clq_pkg::item_t item,
  output clq_pkg::res_t  res
);
  import clq_pkg::*;

  // The element field reaches at most 2**ELEM_W slots.
  localparam int SLOTS  = (MAX_ELEMS < (1 << ELEM_W)) ? MAX_ELEMS : (1 << ELEM_W);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [ELEM_W:0] SLOTS_EXT = (ELEM_W + 1)'(SLOTS);

  logic [SLOT_W-1:0] next_link_r [SLOTS];
  logic [SLOT_W-1:0] prev_link_r [SLOTS];
  logic [SLOT_W-1:0] next_link_nxt [SLOTS];
  logic [SLOT_W-1:0] prev_link_nxt [SLOTS];
  logic [SLOTS-1:0]  linked_r, linked_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              in_pool;
  logic [SLOT_W-1:0] idx;
  logic              is_linked;
  logic [SLOT_W-1:0] succ, pred;
  status_t           status;

  assign in_pool   = {1'b0, item.elem} < SLOTS_EXT;
  assign idx       = item.elem[SLOT_W-1:0];
  assign is_linked = in_pool && linked_r[idx];
  assign succ      = next_link_r[idx];
  assign pred      = prev_link_r[idx];

  always_comb begin
    unique case (item.op)
      OP_APPEND: begin
        if (!in_pool) begin
          status = ST_NOT_FOUND;
        end else if (is_linked) begin
          status = ST_LINKED;
        end else begin
          status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (!nonempty_r) begin
          status = ST_EMPTY;
        end else if (!is_linked) begin
          status = ST_NOT_FOUND;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_NOT_FOUND;
    endcase
  end

  always_comb begin
    next_link_nxt = next_link_r;
    prev_link_nxt = prev_link_r;
    linked_nxt    = linked_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    count_nxt     = count_r;
    if (status == ST_OK) begin
      if (item.op == OP_APPEND) begin
        linked_nxt[idx] = 1'b1;
        count_nxt       = count_r + CNT_W'(1);
        tail_nxt        = idx;
        if (!nonempty_r) begin
          next_link_nxt[idx] = idx;
          prev_link_nxt[idx] = idx;
          head_nxt           = idx;
          nonempty_nxt       = 1'b1;
        end else begin
          // Splice in between tail and head.
          prev_link_nxt[idx]    = tail_r;
          next_link_nxt[idx]    = head_r;
          next_link_nxt[tail_r] = idx;
          prev_link_nxt[head_r] = idx;
        end
      end else begin
        linked_nxt[idx] = 1'b0;
        count_nxt       = count_r - CNT_W'(1);
        if (count_r <= CNT_W'(1)) begin
          nonempty_nxt = 1'b0;
          head_nxt     = '0;
          tail_nxt     = '0;
        end else begin
          prev_link_nxt[succ] = pred;
          next_link_nxt[pred] = succ;
          if (head_r == idx) begin
            head_nxt = succ;
          end
          if (tail_r == idx) begin
            tail_nxt = pred;
          end
        end
      end
    end
  end

  assign res.status     = status;
  assign res.count      = COUNT_W'(count_nxt);
  assign res.head_valid = nonempty_nxt;
  assign res.head       = nonempty_nxt ? ELEM_W'(head_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linked_r   <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      nonempty_r <= 1'b0;
      count_r    <= '0;
    end else if (commit) begin
      linked_r   <= linked_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      nonempty_r <= nonempty_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      next_link_r <= next_link_nxt;
      prev_link_r <= prev_link_nxt;
    end
  end

  a_count_flags : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(linked_r) == int'(count_r))
    else $error("element count does not match linked flags");

  a_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r == (count_r != '0))
    else $error("nonempty flag disagrees with count");

  a_head_tail_linked : assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r |-> (linked_r[head_r] && linked_r[tail_r]))
    else $error("head or tail slot not linked");

  a_empty_head : assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty_r |-> (head_r == '0))
    else $error("head not cleared on empty queue");

endmodule

FILE: hw/rtl/clq_out_reg.sv
// Result register: holds one result transaction until the receiver takes it.
module clq_out_reg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  clq_pkg::res_t res,
  input  logic         out_stall,
  output logic         out_vld_r,
  output clq_pkg::res_t res_r
);
  import clq_pkg::*;

  logic out_vld_nxt;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule

FILE: hw/rtl/circular_linked_queue_manager.sv
// Circular doubly linked queue manager: top level with input register, list update and result register.
//
// Keeps one circular doubly linked queue over a pool of up to 16 element slots. Each input
// transaction appends a slot at the tail (op 0) or unlinks a named slot (op 1), and yields
// exactly one result with status, element count and head. One transaction is accepted every
// cycle while in_stall is low; each result passes through the input register, the list update and
// the result register, and is taken at a clock edge on which the output is not stalled. The rate
// is set by the single-pass update of the link tables, which sit in flip-flops and are read at
// one address each, with a tail register so that an append needs no table read. There is no
// clearing pass after reset: the linked flags reset at once and link entries are only read for
// linked slots.
module circular_linked_queue_manager #(
  parameter int MAX_ELEMS = clq_pkg::DEF_MAX_ELEMS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [clq_pkg::ELEM_W-1:0]   in_elem,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clq_pkg::STATUS_W-1:0] out_status,
  output logic [clq_pkg::COUNT_W-1:0]  out_count,
  output logic                         out_head_valid,
  output logic [clq_pkg::ELEM_W-1:0]   out_head
);
  import clq_pkg::*;

  item_t in_item;
  item_t item_r;
  logic  item_vld_r;
  logic  advance;
  res_t  res;
  res_t  res_r;

  assign in_item.op   = op_t'(in_op);
  assign in_item.elem = in_elem;

  // Move the held transaction on when the result register is free or drains this cycle.
  assign advance = item_vld_r && (!out_valid || !out_stall);

  clq_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .vld_r    (item_vld_r),
    .item_r   (item_r)
  );

  clq_list #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_list (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item_r),
    .res    (res)
  );

  clq_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .out_stall (out_stall),
    .out_vld_r (out_valid),
    .res_r     (res_r)
  );

  assign out_status     = res_r.status;
  assign out_count      = res_r.count;
  assign out_head_valid = res_r.head_valid;
  assign out_head       = res_r.head;

endmodule

FILE: tb/sv/clq_result_board.sv
// Scoreboard package: linked queue predictor and result checker for the queue manager.
`timescale 1ns / 100ps

package clq_board_pkg;
  import clq_pkg::*;

  localparam int SLOTS = DEF_MAX_ELEMS;

  class clq_result_board;
    logic [ELEM_W-1:0] succ_slot[SLOTS];
    logic [ELEM_W-1:0] pred_slot[SLOTS];
    bit                in_queue[SLOTS];
    logic [ELEM_W-1:0] first_slot;
    bit                has_elems;
    int unsigned       num_elems;
    res_t              expected_results[$];
    int                errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        succ_slot[i] = '0;
        pred_slot[i] = '0;
        in_queue[i]  = 1'b0;
      end
      first_slot = '0;
      has_elems  = 1'b0;
      num_elems  = 0;
      errors     = 0;
    endfunction

    function void report(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endfunction

    // Insert just before the head, i.e. at the tail of the ring.
    function status_t link_at_tail(logic [ELEM_W-1:0] e);
      logic [ELEM_W-1:0] tail;
      if (int'(e) >= SLOTS) return ST_NOT_FOUND;
      if (in_queue[e]) return ST_LINKED;
      if (!has_elems) begin
        succ_slot[e] = e;
        pred_slot[e] = e;
        first_slot   = e;
        has_elems    = 1'b1;
      end else begin
        tail               = pred_slot[first_slot];
        pred_slot[e]       = tail;
        succ_slot[e]       = first_slot;
        succ_slot[tail]    = e;
        pred_slot[first_slot] = e;
      end
      in_queue[e] = 1'b1;
      num_elems++;
      return ST_OK;
    endfunction

    function status_t unlink_slot(logic [ELEM_W-1:0] e);
      logic [ELEM_W-1:0] n;
      logic [ELEM_W-1:0] p;
      if (!has_elems) return ST_EMPTY;
      if (int'(e) >= SLOTS || !in_queue[e]) return ST_NOT_FOUND;
      if (num_elems <= 1) begin
        has_elems  = 1'b0;
        first_slot = '0;
      end else begin
        n = succ_slot[e];
        p = pred_slot[e];
        pred_slot[n] = p;
        succ_slot[p] = n;
        if (first_slot == e) first_slot = n;
      end
      in_queue[e] = 1'b0;
      num_elems--;
      return ST_OK;
    endfunction

    function void log_request(op_t op, logic [ELEM_W-1:0] e);
      res_t r;
      r.status     = (op == OP_APPEND) ? link_at_tail(e) : unlink_slot(e);
      r.count      = num_elems[COUNT_W-1:0];
      r.head_valid = has_elems;
      r.head       = has_elems ? first_slot : '0;
      expected_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (expected_results.size() == 0) begin
        report("result transaction with no pending request");
        return;
      end
      exp = expected_results.pop_front();
      if (got.status != exp.status)
        report($sformatf("status got %0d want %0d", got.status, exp.status));
      if (got.count != exp.count)
        report($sformatf("count got %0d want %0d", got.count, exp.count));
      if (got.head_valid != exp.head_valid)
        report($sformatf("head_valid got %0b want %0b", got.head_valid, exp.head_valid));
      if (got.head != exp.head)
        report($sformatf("head got %0d want %0d", got.head, exp.head));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_drained();
      if (expected_results.size() != 0)
        report($sformatf("%0d results never arrived", expected_results.size()));
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench for the circular linked queue manager.
`timescale 1ns / 100ps

module tb_top;
  import clq_pkg::*;
  import clq_board_pkg::*;

  localparam int RANDOM_ITEMS = 450;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [ELEM_W-1:0]   in_elem;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic                out_head_valid;
  logic [ELEM_W-1:0]   out_head;

  clq_result_board board;
  res_t            seen;
  logic [SLOTS-1:0] shadow_linked;
  bit              quiet;
  int              stall_hold;
  int              stall_pick;

  circular_linked_queue_manager dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_elem       (in_elem),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_head_valid(out_head_valid),
    .out_head      (out_head)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pick a slot whose linked flag matches want; fall back to any slot.
  function automatic logic [ELEM_W-1:0] pick_slot(bit want);
    logic [ELEM_W-1:0] cand[$];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_linked[i] == want) cand.push_back(ELEM_W'(i));
    if (cand.size() == 0) return ELEM_W'($urandom_range(0, SLOTS - 1));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic issue(op_t op, logic [ELEM_W-1:0] e);
    int gap;
    if (op == OP_APPEND) shadow_linked[e] = 1'b1;
    else shadow_linked[e] = 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_elem  = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.log_request(op, e);
    @(negedge clk);
  endtask

  // Receiver stall pattern: mostly short bursts, some long holds, some quiet runs.
  initial begin
    out_stall  = 1'b0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) continue;
      if (stall_hold > 0) begin
        stall_hold--;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 50) begin
          out_stall  = 1'b0;
          stall_hold = $urandom_range(0, 10);
        end else if (stall_pick < 88) begin
          out_stall  = 1'b1;
          stall_hold = $urandom_range(0, 2);
        end else if (stall_pick < 95) begin
          out_stall  = 1'b1;
          stall_hold = $urandom_range(10, 40);
        end else begin
          out_stall  = 1'b0;
          stall_hold = $urandom_range(50, 100);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.status     = status_t'(out_status);
      seen.count      = out_count;
      seen.head_valid = out_head_valid;
      seen.head       = out_head;
      board.check_result(seen);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int append_pct;
    op_t op;
    logic [ELEM_W-1:0] e;
    board         = new();
    shadow_linked = '0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = 1'b0;
    in_elem       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, duplicate append, unknown slot, middle/head/tail/last removal.
    issue(OP_REMOVE, 4'd0);
    issue(OP_APPEND, 4'd0);
    issue(OP_APPEND, 4'd0);
    issue(OP_REMOVE, 4'd9);
    issue(OP_APPEND, 4'd15);
    issue(OP_APPEND, 4'd8);
    issue(OP_APPEND, 4'd3);
    issue(OP_REMOVE, 4'd8);
    issue(OP_REMOVE, 4'd0);
    issue(OP_APPEND, 4'd0);
    issue(OP_REMOVE, 4'd3);
    issue(OP_REMOVE, 4'd15);
    issue(OP_REMOVE, 4'd0);
    issue(OP_REMOVE, 4'd15);
    issue(OP_APPEND, 4'd15);
    issue(OP_APPEND, 4'd5);
    issue(OP_REMOVE, 4'd5);
    issue(OP_REMOVE, 4'd15);

    // Random: bursts with varying append bias so the queue both fills and drains.
    append_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 3))
          0: append_pct = 15;
          1: append_pct = 50;
          2: append_pct = 85;
          default: append_pct = 97;
        endcase
        quiet = ($urandom_range(0, 4) == 0);
      end
      op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_REMOVE;
      if ($urandom_range(0, 99) < 85) e = pick_slot(op == OP_REMOVE);
      else e = ELEM_W'($urandom_range(0, SLOTS - 1));
      issue(op, e);
    end
    in_valid = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
